[rtl/qalu_pkg.sv]
// Shared operation codes, Hamilton sign table and saturation helpers.
`default_nettype none
package qalu_pkg;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_SCALE     = 4'd2,
    OP_CONJ      = 4'd3,
    OP_NORM      = 4'd4,
    OP_NORMALIZE = 4'd5,
    OP_EQUAL     = 4'd6,
    OP_ROTMATRIX = 4'd7,
    OP_PRODUCT   = 4'd8,
    OP_ROTATE    = 4'd9
  } op_t;

  localparam int XW = 192;
  localparam logic [15:0] EPS_RESET = 16'd17;

  typedef logic signed [XW-1:0] wide_t;

  // term j of component k is a[j] * b[k ^ j], negated where set
  localparam logic HAM_NEG [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

  function automatic wide_t sat_val(input wide_t v, input int w);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) begin
      sat_val = hi;
    end else if (v < lo) begin
      sat_val = lo;
    end else begin
      sat_val = v;
    end
  endfunction

  function automatic logic sat_ovf(input wide_t v, input int w);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    sat_ovf = (v > hi) || (v < lo);
  endfunction

endpackage
`default_nettype wire

[rtl/qalu_ham.sv]
// Four-lane Hamilton product: registered products, then rounded and saturated sums.
`default_nettype none
module qalu_ham #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] a [4],
  input  logic signed [W-1:0] b [4],
  output logic signed [W-1:0] r [4],
  output logic                ovf
);
  import qalu_pkg::*;

  localparam int W2 = 2 * W;

  logic signed [W2-1:0] prod [4][4];
  logic signed [W-1:0]  r_next [4];
  logic                 ovf_next;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 4; j++) begin
          prod[k][j] <= W2'(a[j] * b[2'(k ^ j)]);
        end
      end
    end
  end

  always_comb begin
    wide_t s;
    wide_t t;
    ovf_next = 1'b0;
    for (int k = 0; k < 4; k++) begin
      s = '0;
      for (int j = 0; j < 4; j++) begin
        t = wide_t'(prod[k][j]);
        s = HAM_NEG[k][j] ? s - t : s + t;
      end
      s = (s + (wide_t'(1) <<< (F - 1))) >>> F;
      r_next[k] = W'(sat_val(s, W));
      ovf_next = ovf_next | sat_ovf(s, W);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r   <= r_next;
      ovf <= ovf_next;
    end
  end

endmodule
`default_nettype wire

[rtl/qalu_sqrt.sv]
// Pipelined rounded integer square root, one result bit per stage.
`default_nettype none
module qalu_sqrt #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         en,
  input  logic [2*W:0] s,
  output logic [W:0]   r
);

  localparam int RB = W + 1;
  localparam int SB = 2 * RB;
  localparam int RW = RB + 3;

  logic [SB-1:0] st_s   [RB-1];
  logic [RB-1:0] st_r   [RB];
  logic [RW-1:0] st_rem [RB];

  for (genvar k = 0; k < RB; k++) begin : g_bit
    localparam int I = RB - 1 - k;
    logic [SB-1:0] s_in;
    logic [RB-1:0] r_in;
    logic [RW-1:0] rem_in;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;

    if (k == 0) begin : g_first
      assign s_in   = SB'(s);
      assign r_in   = '0;
      assign rem_in = '0;
    end else begin : g_next
      assign s_in   = st_s[k-1];
      assign r_in   = st_r[k-1];
      assign rem_in = st_rem[k-1];
    end

    assign rem_sh = {rem_in[RW-3:0], s_in[2*I+1 -: 2]};
    assign trial  = RW'({r_in, 2'b01});

    if (k < RB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          st_s[k] <= s_in;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          st_rem[k] <= rem_sh - trial;
          st_r[k]   <= {r_in[RB-2:0], 1'b1};
        end else begin
          st_rem[k] <= rem_sh;
          st_r[k]   <= {r_in[RB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (st_rem[RB-1] > RW'(st_r[RB-1])) begin
        r <= st_r[RB-1] + 1'b1;
      end else begin
        r <= st_r[RB-1];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/qalu_div.sv]
// Pipelined restoring divider lane, one quotient bit per stage, with a too-large flag.
`default_nettype none
module qalu_div #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W+F-1:0] num,
  input  logic [W:0]     den,
  output logic [W-1:0]   quo,
  output logic           big
);

  localparam int NW = W + F;
  localparam int CW = NW + W + 1;

  logic [NW-1:0] rm [W+1];
  logic [W:0]    dn [W];
  logic          bg [W+1];
  logic [W-1:0]  qt [W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rm[0] <= num;
      dn[0] <= den;
      bg[0] <= CW'(num) >= (CW'(den) << W);
      qt[0] <= '0;
    end
  end

  for (genvar j = 1; j <= W; j++) begin : g_bit
    localparam int I = W - j;
    logic [CW-1:0] sub;
    assign sub = CW'(dn[j-1]) << I;

    if (j < W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dn[j] <= dn[j-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        bg[j] <= bg[j-1];
        if (CW'(rm[j-1]) >= sub) begin
          rm[j] <= NW'(CW'(rm[j-1]) - sub);
          qt[j] <= qt[j-1] | (W'(1) << I);
        end else begin
          rm[j] <= rm[j-1];
          qt[j] <= qt[j-1];
        end
      end
    end
  end

  assign quo = qt[W];
  assign big = bg[W];

endmodule
`default_nettype wire

[rtl/quaternion_alu_unit.sv]
// Top level of the fixed-point quaternion arithmetic unit.
// Fully pipelined: a new transaction is accepted every cycle while the output is
// free or its last row is being taken. Every operation takes the same path from
// acceptance to the result register, a path set by the bit-per-stage square root
// (WORD_WIDTH+2 stages) followed by the bit-per-stage normalize dividers
// (WORD_WIDTH+1 stages) and the two rotate products. The rotation matrix operation
// delivers its three rows on three consecutive output transactions, holding the
// pipeline for the two extra rows.
`default_nettype none
module quaternion_alu_unit #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [15:0]                  cfg_write_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [3:0]                   operation,
  input  logic signed [WORD_WIDTH-1:0] p_w,
  input  logic signed [WORD_WIDTH-1:0] p_x,
  input  logic signed [WORD_WIDTH-1:0] p_y,
  input  logic signed [WORD_WIDTH-1:0] p_z,
  input  logic signed [WORD_WIDTH-1:0] q_w,
  input  logic signed [WORD_WIDTH-1:0] q_x,
  input  logic signed [WORD_WIDTH-1:0] q_y,
  input  logic signed [WORD_WIDTH-1:0] q_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [WORD_WIDTH-1:0] out_w,
  output logic signed [WORD_WIDTH-1:0] out_x,
  output logic signed [WORD_WIDTH-1:0] out_y,
  output logic signed [WORD_WIDTH-1:0] out_z,
  output logic                         overflow,
  output logic                         equal,
  output logic [1:0]                   row_index,
  output logic                         last
);
  import qalu_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int W2 = 2 * W;
  localparam int NW = W + F;
  localparam int LS = W + 2;
  localparam int LD = W + 1;
  localparam int KQ = 2;
  localparam int KN = KQ + LS;
  localparam int KD = KN + LD;
  localparam int KR = KD + 1;
  localparam int KF = KR + 4;

  typedef logic signed [W-1:0] word_t;

  function automatic wide_t rnd_m(input wide_t s);
    rnd_m = (s + (wide_t'(1) <<< (F - 2))) >>> (F - 1);
  endfunction

  logic        adv;
  logic [15:0] equal_epsilon;
  logic [0:KF] v;
  logic [3:0]  opd [0:KF];
  word_t       p0 [4];
  word_t       q0 [4];
  word_t       pd [1:KN][4];
  word_t       qd [1:KR][3];

  assign adv      = !out_valid || (out_ready && last);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      equal_epsilon <= EPS_RESET;
    end else if (cfg_write_en) begin
      equal_epsilon <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v[0] <= in_valid;
      for (int k = 1; k <= KF; k++) begin
        v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      opd[0] <= operation;
      for (int k = 1; k <= KF; k++) begin
        opd[k] <= opd[k-1];
      end
      p0[0] <= p_w;
      p0[1] <= p_x;
      p0[2] <= p_y;
      p0[3] <= p_z;
      q0[0] <= q_w;
      q0[1] <= q_x;
      q0[2] <= q_y;
      q0[3] <= q_z;
      pd[1] <= p0;
      for (int k = 2; k <= KN; k++) begin
        pd[k] <= pd[k-1];
      end
      qd[1][0] <= q0[1];
      qd[1][1] <= q0[2];
      qd[1][2] <= q0[3];
      for (int k = 2; k <= KR; k++) begin
        qd[k] <= qd[k-1];
      end
    end
  end

  // add, sub, conj and equality
  word_t er_next [4];
  logic  er_ov_next;
  logic  er_eq_next;
  word_t er1 [4];
  word_t er2 [4];
  logic  er1_ov, er2_ov, er1_eq, er2_eq;

  always_comb begin
    wide_t pw;
    wide_t qw;
    wide_t t;
    wide_t d;
    er_ov_next = 1'b0;
    er_eq_next = (opd[0] == OP_EQUAL);
    for (int i = 0; i < 4; i++) begin
      pw = wide_t'(p0[i]);
      qw = wide_t'(q0[i]);
      t  = '0;
      d  = '0;
      unique case (opd[0])
        OP_ADD:  t = pw + qw;
        OP_SUB:  t = pw - qw;
        OP_CONJ: t = (i == 0) ? pw : -pw;
        OP_EQUAL: begin
          d = pw - qw;
          if (d < 0) begin
            d = -d;
          end
          if (d >= wide_t'(equal_epsilon)) begin
            er_eq_next = 1'b0;
          end
        end
        default: t = '0;
      endcase
      er_next[i] = W'(sat_val(t, W));
      er_ov_next = er_ov_next | sat_ovf(t, W);
    end
  end

  // squares and rotation matrix products
  logic [W2-1:0]        sq1 [4];
  logic [W2:0]          sumsq;
  logic signed [W2-1:0] mp1 [9];

  always_ff @(posedge clk) begin
    if (adv) begin
      er1    <= er_next;
      er1_ov <= er_ov_next;
      er1_eq <= er_eq_next;
      er2    <= er1;
      er2_ov <= er1_ov;
      er2_eq <= er1_eq;
      for (int i = 0; i < 4; i++) begin
        sq1[i] <= W2'(p0[i] * p0[i]);
      end
      mp1[0] <= W2'(p0[1] * p0[1]);
      mp1[1] <= W2'(p0[2] * p0[2]);
      mp1[2] <= W2'(p0[3] * p0[3]);
      mp1[3] <= W2'(p0[1] * p0[2]);
      mp1[4] <= W2'(p0[1] * p0[3]);
      mp1[5] <= W2'(p0[2] * p0[3]);
      mp1[6] <= W2'(p0[0] * p0[1]);
      mp1[7] <= W2'(p0[0] * p0[2]);
      mp1[8] <= W2'(p0[0] * p0[3]);
      sumsq  <= (W2+1)'(sq1[0]) + (W2+1)'(sq1[1]) + (W2+1)'(sq1[2]) + (W2+1)'(sq1[3]);
    end
  end

  word_t mat_next [9];
  logic  mov_next [3];
  word_t mat_d [2:KF][9];
  logic  mov_d [2:KF][3];

  always_comb begin
    wide_t e [9];
    wide_t one;
    wide_t xx, yy, zz, xy, xz, yz, wx, wy, wz;
    one = wide_t'(1) <<< F;
    xx  = wide_t'(mp1[0]);
    yy  = wide_t'(mp1[1]);
    zz  = wide_t'(mp1[2]);
    xy  = wide_t'(mp1[3]);
    xz  = wide_t'(mp1[4]);
    yz  = wide_t'(mp1[5]);
    wx  = wide_t'(mp1[6]);
    wy  = wide_t'(mp1[7]);
    wz  = wide_t'(mp1[8]);
    e[0] = one + rnd_m(-yy - zz);
    e[1] = rnd_m(xy - wz);
    e[2] = rnd_m(xz + wy);
    e[3] = rnd_m(xy + wz);
    e[4] = one + rnd_m(-xx - zz);
    e[5] = rnd_m(yz - wx);
    e[6] = rnd_m(xz - wy);
    e[7] = rnd_m(yz + wx);
    e[8] = one + rnd_m(-xx - yy);
    for (int r = 0; r < 3; r++) begin
      mov_next[r] = 1'b0;
    end
    for (int i = 0; i < 9; i++) begin
      mat_next[i]  = W'(sat_val(e[i], W));
      mov_next[i/3] = mov_next[i/3] | sat_ovf(e[i], W);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mat_d[2] <= mat_next;
      mov_d[2] <= mov_next;
      for (int k = 3; k <= KF; k++) begin
        mat_d[k] <= mat_d[k-1];
        mov_d[k] <= mov_d[k-1];
      end
    end
  end

  // scale and product
  word_t h1_b [4];
  word_t h1_r [4];
  logic  h1_ov;

  always_comb begin
    h1_b = q0;
    if (opd[0] == OP_SCALE) begin
      h1_b[1] = '0;
      h1_b[2] = '0;
      h1_b[3] = '0;
    end
  end

  qalu_ham #(.W(W), .F(F)) u_ham_pq (
    .clk (clk),
    .en  (adv),
    .a   (p0),
    .b   (h1_b),
    .r   (h1_r),
    .ovf (h1_ov)
  );

  // norm
  logic [W:0] nrm;

  qalu_sqrt #(.W(W)) u_sqrt (
    .clk (clk),
    .en  (adv),
    .s   (sumsq),
    .r   (nrm)
  );

  word_t nm_w;
  logic  nm_ov;
  logic  small_n;
  assign nm_w    = W'(sat_val(wide_t'(nrm), W));
  assign nm_ov   = sat_ovf(wide_t'(nrm), W);
  assign small_n = wide_t'(nrm) <= wide_t'(equal_epsilon);

  // normalize lanes
  logic [W-1:0] quo [4];
  logic         big [4];
  logic         sg [KN+1:KD][4];
  logic         sm [KN+1:KD];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    logic [W-1:0]  mag;
    logic [NW-1:0] num;
    assign mag = pd[KN][i][W-1] ? W'(-pd[KN][i]) : W'(pd[KN][i]);
    assign num = (NW'(mag) << F) + NW'(nrm >> 1);

    qalu_div #(.W(W), .F(F)) u_div (
      .clk (clk),
      .en  (adv),
      .num (num),
      .den (nrm),
      .quo (quo[i]),
      .big (big[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        sg[KN+1][i] <= pd[KN][i][W-1];
      end
      sm[KN+1] <= small_n;
      for (int k = KN + 2; k <= KD; k++) begin
        sg[k] <= sg[k-1];
        sm[k] <= sm[k-1];
      end
    end
  end

  word_t n_next [4];
  logic  nov_next;
  word_t nq [4];
  logic  nov;

  always_comb begin
    wide_t m;
    nov_next = 1'b0;
    for (int i = 0; i < 4; i++) begin
      m = big[i] ? (wide_t'(1) <<< W) : wide_t'(quo[i]);
      m = sg[KD][i] ? -m : m;
      if (sm[KD]) begin
        n_next[i] = '0;
      end else begin
        n_next[i] = W'(sat_val(m, W));
        nov_next  = nov_next | sat_ovf(m, W);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nq  <= n_next;
      nov <= nov_next;
    end
  end

  // rotate: n * (0, v) * conj(n)
  word_t h2_b [4];
  word_t h2_r [4];
  logic  h2_ov;
  word_t cj [4];
  logic  cj_ov;
  word_t cj_a [4];
  word_t cj_b [4];
  logic  rov_a, rov_b, rov_c, rov_d;
  word_t h3_r [4];
  logic  h3_ov;

  assign h2_b[0] = '0;
  assign h2_b[1] = qd[KR][0];
  assign h2_b[2] = qd[KR][1];
  assign h2_b[3] = qd[KR][2];

  qalu_ham #(.W(W), .F(F)) u_ham_nv (
    .clk (clk),
    .en  (adv),
    .a   (nq),
    .b   (h2_b),
    .r   (h2_r),
    .ovf (h2_ov)
  );

  always_comb begin
    cj_ov = 1'b0;
    cj[0] = nq[0];
    for (int i = 1; i < 4; i++) begin
      cj[i] = W'(sat_val(-wide_t'(nq[i]), W));
      cj_ov = cj_ov | sat_ovf(-wide_t'(nq[i]), W);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cj_a  <= cj;
      cj_b  <= cj_a;
      rov_a <= nov | cj_ov;
      rov_b <= rov_a;
      rov_c <= rov_b | h2_ov;
      rov_d <= rov_c;
    end
  end

  qalu_ham #(.W(W), .F(F)) u_ham_tc (
    .clk (clk),
    .en  (adv),
    .a   (h2_r),
    .b   (cj_b),
    .r   (h3_r),
    .ovf (h3_ov)
  );

  // merge per-operation results along the pipe
  word_t rs_v  [3:KF][4];
  logic  rs_ov [3:KF];
  logic  rs_eq [3:KF];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (opd[2] == OP_SCALE || opd[2] == OP_PRODUCT) begin
        rs_v[3]  <= h1_r;
        rs_ov[3] <= h1_ov;
      end else begin
        rs_v[3]  <= er2;
        rs_ov[3] <= er2_ov;
      end
      rs_eq[3] <= er2_eq;
      for (int k = 4; k <= KF; k++) begin
        if (k == KN + 1 && opd[KN] == OP_NORM) begin
          rs_v[k][0] <= nm_w;
          rs_v[k][1] <= '0;
          rs_v[k][2] <= '0;
          rs_v[k][3] <= '0;
          rs_ov[k]   <= nm_ov;
          rs_eq[k]   <= 1'b0;
        end else if (k == KR + 1 && opd[KR] == OP_NORMALIZE) begin
          rs_v[k]  <= nq;
          rs_ov[k] <= nov;
          rs_eq[k] <= 1'b0;
        end else begin
          rs_v[k]  <= rs_v[k-1];
          rs_ov[k] <= rs_ov[k-1];
          rs_eq[k] <= rs_eq[k-1];
        end
      end
    end
  end

  // output stage
  word_t fw [4];
  logic  fov;
  logic  feq;
  logic  fmat;
  word_t mh [6];
  logic  mhov [2];

  always_comb begin
    fmat = (opd[KF] == OP_ROTMATRIX);
    if (opd[KF] == OP_ROTATE) begin
      fw  = h3_r;
      fov = rov_d | h3_ov;
      feq = 1'b0;
    end else if (fmat) begin
      fw[0] = '0;
      fw[1] = mat_d[KF][0];
      fw[2] = mat_d[KF][1];
      fw[3] = mat_d[KF][2];
      fov   = mov_d[KF][0];
      feq   = 1'b0;
    end else begin
      fw  = rs_v[KF];
      fov = rs_ov[KF];
      feq = rs_eq[KF];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[KF];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_w     <= fw[0];
      out_x     <= fw[1];
      out_y     <= fw[2];
      out_z     <= fw[3];
      overflow  <= fov;
      equal     <= feq;
      row_index <= 2'd0;
      last      <= !fmat;
      for (int i = 0; i < 6; i++) begin
        mh[i] <= mat_d[KF][i+3];
      end
      mhov[0] <= mov_d[KF][1];
      mhov[1] <= mov_d[KF][2];
    end else if (out_valid && out_ready) begin
      row_index <= row_index + 2'd1;
      last      <= (row_index == 2'd1);
      out_w     <= '0;
      if (row_index == 2'd0) begin
        out_x    <= mh[0];
        out_y    <= mh[1];
        out_z    <= mh[2];
        overflow <= mhov[0];
      end else begin
        out_x    <= mh[3];
        out_y    <= mh[4];
        out_z    <= mh[5];
        overflow <= mhov[1];
      end
    end
  end

endmodule
`default_nettype wire

[test/quaternion_alu_unit_tb.sv]
// Testbench for the fixed-point quaternion unit: predicted results checked in order.
`default_nettype none
module quaternion_alu_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qalu_pkg::*;

  localparam int W = 32;
  localparam int FB = 24;
  localparam longint WMAXV = 64'sd2147483647;
  localparam longint WMINV = -64'sd2147483648;
  localparam longint ONE_Q = 64'sd1 << FB;
  localparam int PIPE_DEPTH = 2 * W + 11;

  typedef struct {
    logic signed [W-1:0] w, x, y, z;
    logic ovf, eq;
    logic [1:0] row;
    logic lst;
  } qres_t;

  typedef struct {
    logic [3:0] op;
    logic signed [W-1:0] p[4];
    logic signed [W-1:0] q[4];
  } qitem_t;

  class quat_scoreboard;
    qres_t pending[$];
    int errors;
    int results_seen;
    int items_seen;
    int rows_seen;
    logic [15:0] eps;

    function longint clamp(longint v, ref bit ov);
      if (v > WMAXV) begin
        ov = 1;
        return WMAXV;
      end
      if (v < WMINV) begin
        ov = 1;
        return WMINV;
      end
      return v;
    endfunction

    // exact round-to-nearest, ties up, of a sum of 128-bit terms
    function longint round_terms(logic signed [127:0] t[4], int n, int s);
      logic signed [127:0] acc;
      acc = 0;
      for (int i = 0; i < n; i++) acc += t[i];
      acc = acc + (128'sd1 <<< (s - 1));
      return longint'(acc >>> s);
    endfunction

    function void hprod(longint a[4], longint b[4], ref longint r[4], ref bit ov);
      logic signed [127:0] t[4];
      t[0] = a[0]*b[0]; t[1] = -(a[1]*b[1]); t[2] = -(a[2]*b[2]); t[3] = -(a[3]*b[3]);
      r[0] = clamp(round_terms(t, 4, FB), ov);
      t[0] = a[0]*b[1]; t[1] = a[1]*b[0]; t[2] = a[2]*b[3]; t[3] = -(a[3]*b[2]);
      r[1] = clamp(round_terms(t, 4, FB), ov);
      t[0] = a[0]*b[2]; t[1] = -(a[1]*b[3]); t[2] = a[2]*b[0]; t[3] = a[3]*b[1];
      r[2] = clamp(round_terms(t, 4, FB), ov);
      t[0] = a[0]*b[3]; t[1] = a[1]*b[2]; t[2] = -(a[2]*b[1]); t[3] = a[3]*b[0];
      r[3] = clamp(round_terms(t, 4, FB), ov);
    endfunction

    function longint magnitude(longint p[4]);
      logic [127:0] s;
      logic [127:0] lo, hi, mid, r;
      s = 0;
      for (int i = 0; i < 4; i++) s += 128'(p[i] * p[i]);
      if (s >= (128'd1 << 64)) return 64'sd1 << 32;
      lo = 0;
      hi = 128'd1 << 33;
      while (hi - lo > 1) begin
        mid = (lo + hi) >> 1;
        if (mid * mid <= s) lo = mid;
        else hi = mid;
      end
      r = lo;
      if (s - r * r > r) r++;
      return longint'(r);
    endfunction

    function void unit_of(longint p[4], ref longint r[4], ref bit ov);
      longint n, mag, qq;
      n = magnitude(p);
      if (n <= longint'(eps)) begin
        for (int i = 0; i < 4; i++) r[i] = 0;
        return;
      end
      for (int i = 0; i < 4; i++) begin
        mag = p[i] < 0 ? -p[i] : p[i];
        qq = ((mag << FB) + (n >> 1)) / n;
        r[i] = clamp(p[i] < 0 ? -qq : qq, ov);
      end
    endfunction

    function void push(longint r[4], bit ov, bit eq, int row, bit lst);
      qres_t e;
      e.w = r[0]; e.x = r[1]; e.y = r[2]; e.z = r[3];
      e.ovf = ov; e.eq = eq; e.row = row; e.lst = lst;
      pending.push_back(e);
    endfunction

    function void note_item(qitem_t it);
      longint p[4], q[4], r[4], t[4], n[4], m[3][3];
      logic signed [127:0] tt[4];
      longint x, y, z, w;
      bit ov, eq;
      ov = 0;
      eq = 0;
      items_seen++;
      for (int i = 0; i < 4; i++) begin
        p[i] = it.p[i];
        q[i] = it.q[i];
        r[i] = 0;
      end
      case (it.op)
        OP_ADD: for (int i = 0; i < 4; i++) r[i] = clamp(p[i] + q[i], ov);
        OP_SUB: for (int i = 0; i < 4; i++) r[i] = clamp(p[i] - q[i], ov);
        OP_SCALE: for (int i = 0; i < 4; i++) begin
          tt[0] = p[i] * q[0];
          r[i] = clamp(round_terms(tt, 1, FB), ov);
        end
        OP_CONJ: begin
          r[0] = p[0];
          for (int i = 1; i < 4; i++) r[i] = clamp(-p[i], ov);
        end
        OP_NORM: r[0] = clamp(magnitude(p), ov);
        OP_NORMALIZE: unit_of(p, r, ov);
        OP_EQUAL: begin
          eq = 1;
          for (int i = 0; i < 4; i++)
            if ((p[i] > q[i] ? p[i] - q[i] : q[i] - p[i]) >= longint'(eps)) eq = 0;
        end
        OP_ROTMATRIX: begin
          w = p[0]; x = p[1]; y = p[2]; z = p[3];
          tt[0] = -(y*y); tt[1] = -(z*z); m[0][0] = ONE_Q + round_terms(tt, 2, FB-1);
          tt[0] = x*y; tt[1] = -(w*z);    m[0][1] = round_terms(tt, 2, FB-1);
          tt[0] = x*z; tt[1] = w*y;       m[0][2] = round_terms(tt, 2, FB-1);
          tt[0] = x*y; tt[1] = w*z;       m[1][0] = round_terms(tt, 2, FB-1);
          tt[0] = -(x*x); tt[1] = -(z*z); m[1][1] = ONE_Q + round_terms(tt, 2, FB-1);
          tt[0] = y*z; tt[1] = -(w*x);    m[1][2] = round_terms(tt, 2, FB-1);
          tt[0] = x*z; tt[1] = -(w*y);    m[2][0] = round_terms(tt, 2, FB-1);
          tt[0] = y*z; tt[1] = w*x;       m[2][1] = round_terms(tt, 2, FB-1);
          tt[0] = -(x*x); tt[1] = -(y*y); m[2][2] = ONE_Q + round_terms(tt, 2, FB-1);
          for (int row = 0; row < 3; row++) begin
            bit rov;
            rov = 0;
            r[0] = 0;
            for (int i = 0; i < 3; i++) r[1+i] = clamp(m[row][i], rov);
            push(r, rov, 0, row, row == 2);
          end
          return;
        end
        OP_PRODUCT: hprod(p, q, r, ov);
        OP_ROTATE: begin
          unit_of(p, n, ov);
          q[0] = 0;
          hprod(n, q, t, ov);
          for (int i = 1; i < 4; i++) n[i] = clamp(-n[i], ov);
          hprod(t, n, r, ov);
        end
        default: ;
      endcase
      push(r, ov, eq, 0, 1);
    endfunction

    function void report(string f, logic [31:0] e, logic [31:0] a);
      $display("%0t: %s mismatch expected %h actual %h", $time, f, e, a);
      errors++;
    endfunction

    function void check_result(qres_t a);
      qres_t e;
      results_seen++;
      if (a.row != 0) rows_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result w=%h x=%h y=%h z=%h", $time, a.w, a.x, a.y, a.z);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.w !== e.w) report("out_w", e.w, a.w);
      if (a.x !== e.x) report("out_x", e.x, a.x);
      if (a.y !== e.y) report("out_y", e.y, a.y);
      if (a.z !== e.z) report("out_z", e.z, a.z);
      if (a.ovf !== e.ovf) report("overflow", e.ovf, a.ovf);
      if (a.eq !== e.eq) report("equal", e.eq, a.eq);
      if (a.row !== e.row) report("row_index", e.row, a.row);
      if (a.lst !== e.lst) report("last", e.lst, a.lst);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write_en = 0;
  logic [15:0] cfg_write_data = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [3:0] operation = 0;
  logic signed [W-1:0] p_w = 0, p_x = 0, p_y = 0, p_z = 0;
  logic signed [W-1:0] q_w = 0, q_x = 0, q_y = 0, q_z = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [W-1:0] out_w, out_x, out_y, out_z;
  logic overflow, equal, last;
  logic [1:0] row_index;

  quat_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;

  quaternion_alu_unit #(.WORD_WIDTH(W), .FRAC_BITS(FB)) u_dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // receiver side: stall at random, check each transaction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      qres_t a;
      a.w = out_w; a.x = out_x; a.y = out_y; a.z = out_z;
      a.ovf = overflow; a.eq = equal; a.row = row_index; a.lst = last;
      sb.check_result(a);
    end
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic signed [W-1:0] rand_word();
    case ($urandom_range(7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3, 4: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
      5: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(qitem_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    operation <= it.op;
    p_w <= it.p[0]; p_x <= it.p[1]; p_y <= it.p[2]; p_z <= it.p[3];
    q_w <= it.q[0]; q_x <= it.q[1]; q_y <= it.q[2]; q_z <= it.q[3];
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
  endtask

  task automatic send_fields(logic [3:0] op, logic signed [W-1:0] a, logic signed [W-1:0] b);
    qitem_t it;
    it.op = op;
    for (int i = 0; i < 4; i++) begin
      it.p[i] = a;
      it.q[i] = b;
    end
    send(it);
  endtask

  task automatic send_random(int n);
    qitem_t it;
    for (int k = 0; k < n; k++) begin
      it.op = ($urandom_range(19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(9));
      for (int i = 0; i < 4; i++) begin
        it.p[i] = rand_word();
        it.q[i] = rand_word();
      end
      if (it.op == OP_EQUAL && $urandom_range(1))
        for (int i = 0; i < 4; i++) it.q[i] = it.p[i] + $signed($urandom_range(0, 40)) - 20;
      if (it.op == OP_NORMALIZE && $urandom_range(3) == 0)
        for (int i = 0; i < 4; i++) it.p[i] = $signed($urandom_range(0, 16)) - 8;
      send(it);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  task automatic write_eps(logic [15:0] v);
    cfg_write_en <= 1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 0;
    sb.eps = v;
  endtask

  initial begin
    sb = new();
    sb.eps = EPS_RESET;
    send_idle_pct = 17;
    recv_idle_pct = 88;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int op = 0; op < 16; op++) send_fields(op[3:0], 32'sh7fffffff, 32'sh80000000);
    send_fields(OP_NORMALIZE, 32'sd4, 0);
    send_fields(OP_ROTATE, 32'sd8, 32'sd1 << FB);
    send_fields(OP_EQUAL, 32'sd100, 32'sd116);
    send_fields(OP_EQUAL, 32'sd100, 32'sd117);
    send_fields(OP_CONJ, 32'sh80000000, 0);
    send_fields(OP_ROTMATRIX, 32'sd1 << (FB - 1), 0);
    send_fields(OP_PRODUCT, 32'sh80000000, 32'sh80000000);
    send_random(100);

    drain();
    write_eps(16'd0);
    send_random(40);
    drain();
    write_eps(16'hffff);
    send_idle_pct = 88;
    recv_idle_pct = 17;
    send_random(100);
    drain();
    write_eps(16'd3000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(110);
    drain();

    $display("Covered %0d input transactions and %0d results (%0d non-zero matrix rows)",
             sb.items_seen, sb.results_seen, sb.rows_seen);
    $display("across four tolerance settings and three idling patterns.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
